// ----- sv/crm_pkg.sv -----
`timescale 1ns / 1ps

package crm_pkg;

    // Field widths fixed by the CIGAR entry format
    localparam int OP_W      = 4;
    localparam int IN_LEN_W  = 28;

    // Results one entry can cause, and result queue depth
    localparam int MAX_RES   = 3;
    localparam int RES_CNT_W = 2;
    localparam int Q_DEPTH   = 4;
    localparam int Q_CNT_W   = 3;

    typedef logic [OP_W-1:0] op_t;

    // CIGAR op codes of interest
    localparam op_t OP_NONE = 4'd0;
    localparam op_t OP_INS  = 4'd1;
    localparam op_t OP_SOFT = 4'd4;

    // Everything of a result item except its length
    typedef struct packed {
        op_t  op;
        logic last;
        logic empty;
        logic sat;
    } res_tag_t;

endpackage

// ----- sv/crm_merge.sv -----
`timescale 1ns / 1ps

module crm_merge
    import crm_pkg::*;
#(
    parameter int LEN_BITS = 28
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 step,
    input  op_t                                  op,
    input  logic [IN_LEN_W-1:0]                  len_in,
    input  logic                                 rec_end,
    output logic [RES_CNT_W-1:0]                 res_cnt,
    output res_tag_t [MAX_RES-1:0]               res_tag,
    output logic [MAX_RES-1:0][LEN_BITS-1:0]     res_len
);

    localparam logic [32:0]          LEN_MAX_W = (33'd1 << LEN_BITS) - 33'd1;
    localparam logic [LEN_BITS-1:0]  LEN_MAX   = {LEN_BITS{1'b1}};

    typedef struct packed {
        logic                vld;
        op_t                 op;
        logic [LEN_BITS-1:0] len;
        logic                sat;
    } run_t;

    typedef struct packed {
        run_t run;
        logic emit_vld;
        run_t emit;
    } add_res_t;

    // Fold one entry into the open run, emitting the run when the op changes
    function automatic add_res_t add_run(input run_t r, input logic en, input op_t a_op,
                                         input logic [LEN_BITS-1:0] a_len, input logic a_sat);
        add_res_t          res;
        logic [LEN_BITS:0] sum;
        res          = '{run: r, emit_vld: 1'b0, emit: r};
        sum          = {1'b0, r.len} + {1'b0, a_len};
        if (en && (a_len != '0))
        begin
            if (r.vld && (r.op == a_op))
            begin
                res.run.len = sum[LEN_BITS] ? LEN_MAX : sum[LEN_BITS-1:0];
                res.run.sat = r.sat | sum[LEN_BITS] | a_sat;
            end
            else
            begin
                res.emit_vld = r.vld;
                res.run      = '{vld: 1'b1, op: a_op, len: a_len, sat: a_sat};
            end
        end
        return res;
    endfunction

    // Merge state
    logic                lead_reg, lead_next;
    run_t                run_reg, run_next;
    logic                tail_open_reg, tail_open_next;
    logic [LEN_BITS-1:0] tail_len_reg, tail_len_next;
    logic                tail_sat_reg, tail_sat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg      <= 1'b1;
            run_reg       <= '0;
            tail_open_reg <= 1'b0;
            tail_len_reg  <= '0;
            tail_sat_reg  <= 1'b0;
        end
        else if (step)
        begin
            lead_reg      <= lead_next;
            run_reg       <= run_next;
            tail_open_reg <= tail_open_next;
            tail_len_reg  <= tail_len_next;
            tail_sat_reg  <= tail_sat_next;
        end
    end

    // Entry handling: clamp, tail update, up to two run folds, record close
    always_comb
    begin
        logic [32:0]               len_wide;
        logic                      in_sat;
        logic [LEN_BITS-1:0]       len_c;
        logic                      is_ins;
        logic [LEN_BITS:0]         tail_sum;
        logic [LEN_BITS-1:0]       tail_new;
        logic                      tail_sat_new;
        run_t                      c1_run;
        logic                      c1_en;
        op_t                       c1_op;
        logic [LEN_BITS-1:0]       c1_len;
        logic                      c1_sat;
        add_res_t                  c1;
        add_res_t                  c2;
        logic [MAX_RES-1:0]        e_vld;
        res_tag_t [MAX_RES-1:0]    e_tag;
        logic [MAX_RES-1:0][LEN_BITS-1:0] e_len;
        logic [RES_CNT_W-1:0]      cnt;

        len_wide     = 33'(len_in);
        in_sat       = len_wide > LEN_MAX_W;
        len_c        = in_sat ? LEN_MAX : len_wide[LEN_BITS-1:0];
        is_ins       = (op == OP_INS);

        tail_sum     = {1'b0, tail_len_reg} + {1'b0, len_c};
        tail_new     = tail_sum[LEN_BITS] ? LEN_MAX : tail_sum[LEN_BITS-1:0];
        tail_sat_new = tail_sat_reg | tail_sum[LEN_BITS] | in_sat;

        lead_next      = lead_reg;
        tail_open_next = tail_open_reg;
        tail_len_next  = tail_len_reg;
        tail_sat_next  = tail_sat_reg;
        c1_run         = run_reg;

        // first fold: leading insertion, closing tail, or tail turned insertion
        if (is_ins && lead_reg)
        begin
            c1_en  = 1'b1;
            c1_op  = OP_SOFT;
            c1_len = len_c;
            c1_sat = in_sat;
        end
        else if (is_ins)
        begin
            tail_open_next = 1'b1;
            tail_len_next  = tail_new;
            tail_sat_next  = tail_sat_new;
            c1_en  = rec_end;
            c1_op  = OP_SOFT;
            c1_len = tail_new;
            c1_sat = tail_sat_new;
        end
        else
        begin
            lead_next      = 1'b0;
            tail_open_next = 1'b0;
            tail_len_next  = '0;
            tail_sat_next  = 1'b0;
            c1_en  = tail_open_reg;
            c1_op  = OP_INS;
            c1_len = tail_len_reg;
            c1_sat = tail_sat_reg;
        end

        c1 = add_run(c1_run, c1_en, c1_op, c1_len, c1_sat);
        // second fold: the non-insertion entry itself
        c2 = add_run(c1.run, !is_ins, op, len_c, in_sat);

        run_next = c2.run;

        e_vld[0] = c1.emit_vld;
        e_tag[0] = '{op: c1.emit.op, last: 1'b0, empty: 1'b0, sat: c1.emit.sat};
        e_len[0] = c1.emit.len;
        e_vld[1] = c2.emit_vld;
        e_tag[1] = '{op: c2.emit.op, last: 1'b0, empty: 1'b0, sat: c2.emit.sat};
        e_len[1] = c2.emit.len;
        e_vld[2] = rec_end;
        if (c2.run.vld)
        begin
            e_tag[2] = '{op: c2.run.op, last: 1'b1, empty: 1'b0, sat: c2.run.sat};
            e_len[2] = c2.run.len;
        end
        else
        begin
            e_tag[2] = '{op: OP_NONE, last: 1'b1, empty: 1'b1, sat: 1'b0};
            e_len[2] = '0;
        end

        // record closed: back to the reset state
        if (rec_end)
        begin
            lead_next      = 1'b1;
            run_next       = '0;
            tail_open_next = 1'b0;
            tail_len_next  = '0;
            tail_sat_next  = 1'b0;
        end

        // pack the results in order
        cnt     = '0;
        res_tag = '0;
        res_len = '0;
        for (int k = 0; k < MAX_RES; k++)
        begin
            if (e_vld[k])
            begin
                res_tag[cnt] = e_tag[k];
                res_len[cnt] = e_len[k];
                cnt          = cnt + 1'b1;
            end
        end
        res_cnt = cnt;
    end

endmodule

// ----- sv/crm_queue.sv -----
`timescale 1ns / 1ps

module crm_queue
    import crm_pkg::*;
#(
    parameter int LEN_BITS = 28
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic [RES_CNT_W-1:0]             push_cnt,
    input  res_tag_t [MAX_RES-1:0]           push_tag,
    input  logic [MAX_RES-1:0][LEN_BITS-1:0] push_len,
    output logic                             room,
    output logic                             head_vld,
    input  logic                             head_rdy,
    output res_tag_t                         head_tag,
    output logic [LEN_BITS-1:0]              head_len
);

    // Shifting queue: slot 0 is always the head
    res_tag_t            tag_reg [Q_DEPTH];
    res_tag_t            tag_next [Q_DEPTH];
    logic [LEN_BITS-1:0] len_reg [Q_DEPTH];
    logic [LEN_BITS-1:0] len_next [Q_DEPTH];
    logic [Q_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                pop;

    assign head_vld = (cnt_reg != '0);
    assign head_tag = tag_reg[0];
    assign head_len = len_reg[0];
    assign pop      = head_vld && head_rdy;
    // room for every result of the waiting item, without counting on a pop
    assign room     = ({1'b0, cnt_reg} + 4'(push_cnt)) <= 4'(Q_DEPTH);

    always_comb
    begin
        logic [Q_CNT_W-1:0] base;
        logic [Q_CNT_W-1:0] j;
        base = cnt_reg - Q_CNT_W'(pop);
        for (int i = 0; i < Q_DEPTH; i++)
        begin
            j           = Q_CNT_W'(i) - base;
            tag_next[i] = tag_reg[i];
            len_next[i] = len_reg[i];
            if (Q_CNT_W'(i) < base)
            begin
                if (pop)
                begin
                    tag_next[i] = tag_reg[(i + 1 < Q_DEPTH) ? i + 1 : i];
                    len_next[i] = len_reg[(i + 1 < Q_DEPTH) ? i + 1 : i];
                end
            end
            else if (push && (j < Q_CNT_W'(push_cnt)))
            begin
                tag_next[i] = push_tag[j[RES_CNT_W-1:0]];
                len_next[i] = push_len[j[RES_CNT_W-1:0]];
            end
        end
        cnt_next = base + (push ? Q_CNT_W'(push_cnt) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < Q_DEPTH; i++)
        begin
            tag_reg[i] <= tag_next[i];
            len_reg[i] <= len_next[i];
        end
    end

endmodule

// ----- sv/cigar_run_merge_core.sv -----
`timescale 1ns / 1ps

// Channel   Handshake              Item fields
// -------   --------------------   -----------------------------------------------
// in        in_valid / in_ready    op_code, op_length, record_end
// out       out_valid / out_ready  merged_op, merged_length, last_of_record,
//                                  record_empty, length_saturated
//
// One CIGAR entry per cycle while the queue has room: entry register, one pass of
// merge logic, then a four-slot result queue. An entry waits in the entry register
// while the queue lacks room for all of its results, a result leaving in that cycle
// not counted; one result drains per cycle while out_ready is high.
// Reset opens a fresh record and empties both the entry register and the queue.

module cigar_run_merge_core
    import crm_pkg::*;
#(
    parameter int LEN_BITS = 28
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  op_t                 op_code,
    input  logic [IN_LEN_W-1:0] op_length,
    input  logic                record_end,
    output logic                out_valid,
    input  logic                out_ready,
    output op_t                 merged_op,
    output logic [LEN_BITS-1:0] merged_length,
    output logic                last_of_record,
    output logic                record_empty,
    output logic                length_saturated
);

    // Entry register
    logic                in_vld_reg, in_vld_next;
    op_t                 op_reg;
    logic [IN_LEN_W-1:0] len_reg;
    logic                end_reg;
    logic                step;
    logic                room;

    logic [RES_CNT_W-1:0]             res_cnt;
    res_tag_t [MAX_RES-1:0]           res_tag;
    logic [MAX_RES-1:0][LEN_BITS-1:0] res_len;
    res_tag_t                         head_tag;

    assign step        = in_vld_reg && room;
    assign in_ready    = !in_vld_reg || step;
    assign in_vld_next = (in_valid && in_ready) || (in_vld_reg && !step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg  <= op_code;
            len_reg <= op_length;
            end_reg <= record_end;
        end
    end

    crm_merge #(
        .LEN_BITS (LEN_BITS)
    ) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .op      (op_reg),
        .len_in  (len_reg),
        .rec_end (end_reg),
        .res_cnt (res_cnt),
        .res_tag (res_tag),
        .res_len (res_len)
    );

    crm_queue #(
        .LEN_BITS (LEN_BITS)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (step),
        .push_cnt (res_cnt),
        .push_tag (res_tag),
        .push_len (res_len),
        .room     (room),
        .head_vld (out_valid),
        .head_rdy (out_ready),
        .head_tag (head_tag),
        .head_len (merged_length)
    );

    assign merged_op        = head_tag.op;
    assign last_of_record   = head_tag.last;
    assign record_empty     = head_tag.empty;
    assign length_saturated = head_tag.sat;

    // A record's final entry always closes with at least one result
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step && end_reg |-> res_cnt != '0)
        else $error("record end produced no result");

    // The empty marker only ever closes a record, with zero length
    a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_empty |-> last_of_record && merged_length == '0
                                      && !length_saturated)
        else $error("malformed empty-record result");

    // Zero-length entries never survive the merge
    a_no_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !record_empty |-> merged_length != '0)
        else $error("zero-length merged entry");

endmodule

// ----- tb/tb_cigar_run_merge_core.sv -----
`timescale 1ns / 1ps

module tb_cigar_run_merge_core;
    import crm_pkg::*;

    localparam int LEN_BITS = 28;
    localparam longint unsigned LEN_MAX = (64'd1 << LEN_BITS) - 64'd1;
    localparam logic [IN_LEN_W-1:0] IN_MAX = '1;

    // Remaining CIGAR op codes used by the stimulus
    localparam op_t OP_MATCH    = 4'd0;
    localparam op_t OP_DEL      = 4'd2;
    localparam op_t OP_SKIP     = 4'd3;
    localparam op_t OP_HARD     = 4'd5;
    localparam op_t OP_PAD      = 4'd6;
    localparam op_t OP_SEQ_EQ   = 4'd7;
    localparam op_t OP_SEQ_DIFF = 4'd8;
    localparam op_t OP_TOP      = 4'd15;

    localparam int RANDOM_ENTRIES = 450;

    typedef struct packed {
        op_t                 op;
        logic [LEN_BITS-1:0] len;
        logic                last;
        logic                empty;
        logic                sat;
    } merged_entry_t;

    // Tracks the merge state of the current record and the merged entries owed
    class merge_scoreboard;
        merged_entry_t    merged_due[$];
        int               errors;
        int               reported;
        bit               leading;
        bit               run_valid;
        op_t              run_op;
        longint unsigned  run_len;
        bit               run_sat;
        bit               tail_open;
        longint unsigned  tail_len;
        bit               tail_sat;

        function new();
            errors   = 0;
            reported = 0;
            clear_record();
        endfunction

        function void clear_record();
            leading   = 1'b1;
            run_valid = 1'b0;
            run_op    = OP_NONE;
            run_len   = 0;
            run_sat   = 1'b0;
            tail_open = 1'b0;
            tail_len  = 0;
            tail_sat  = 1'b0;
        endfunction

        function int pending();
            return merged_due.size();
        endfunction

        function void owe(op_t op, longint unsigned len, bit last, bit empty, bit sat);
            merged_entry_t e;
            e.op    = op;
            e.len   = len[LEN_BITS-1:0];
            e.last  = last;
            e.empty = empty;
            e.sat   = sat;
            merged_due.push_back(e);
        endfunction

        // Saturating length sum
        function longint unsigned add_len(longint unsigned a, longint unsigned b,
                                          inout bit sat);
            longint unsigned s;
            s = a + b;
            if (s > LEN_MAX)
            begin
                sat = 1'b1;
                s   = LEN_MAX;
            end
            return s;
        endfunction

        // Fold an entry into the open run, closing the run on an op change
        function void extend_run(op_t op, longint unsigned len, bit sat);
            if (len == 0)
                return;
            if (run_valid && run_op == op)
            begin
                run_len = add_len(run_len, len, run_sat);
                if (sat)
                    run_sat = 1'b1;
                return;
            end
            if (run_valid)
                owe(run_op, run_len, 1'b0, 1'b0, run_sat);
            run_valid = 1'b1;
            run_op    = op;
            run_len   = len;
            run_sat   = sat;
        endfunction

        function void take_entry(op_t op, logic [IN_LEN_W-1:0] len_in, logic rec_end);
            longint unsigned len;
            bit              in_sat;
            len    = len_in;
            in_sat = 1'b0;
            if (len > LEN_MAX)
            begin
                len    = LEN_MAX;
                in_sat = 1'b1;
            end

            if (op == OP_INS && leading)
                extend_run(OP_SOFT, len, in_sat);
            else if (op == OP_INS)
            begin
                // possible trailing insertions, held back
                tail_open = 1'b1;
                tail_len  = add_len(tail_len, len, tail_sat);
                if (in_sat)
                    tail_sat = 1'b1;
            end
            else
            begin
                leading = 1'b0;
                if (tail_open)
                    extend_run(OP_INS, tail_len, tail_sat);
                tail_open = 1'b0;
                tail_len  = 0;
                tail_sat  = 1'b0;
                extend_run(op, len, in_sat);
            end

            if (rec_end)
            begin
                if (tail_open)
                    extend_run(OP_SOFT, tail_len, tail_sat);
                if (run_valid)
                    owe(run_op, run_len, 1'b1, 1'b0, run_sat);
                else
                    owe(OP_NONE, 0, 1'b1, 1'b1, 1'b0);
                clear_record();
            end
        endfunction

        function void check_merged(merged_entry_t got);
            merged_entry_t want;
            if (merged_due.size() == 0)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("%0t: unexpected merged entry op %0d len %0d last %0b empty %0b sat %0b",
                             $realtime, got.op, got.len, got.last, got.empty, got.sat);
                end
                return;
            end
            want = merged_due.pop_front();
            if (got !== want)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("%0t: merged entry mismatch", $realtime);
                    $display("  expected op %0d len %0d last %0b empty %0b sat %0b",
                             want.op, want.len, want.last, want.empty, want.sat);
                    $display("  actual   op %0d len %0d last %0b empty %0b sat %0b",
                             got.op, got.len, got.last, got.empty, got.sat);
                end
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    op_t                 op_code;
    logic [IN_LEN_W-1:0] op_length;
    logic                record_end;
    logic                out_valid;
    logic                out_ready;
    op_t                 merged_op;
    logic [LEN_BITS-1:0] merged_length;
    logic                last_of_record;
    logic                record_empty;
    logic                length_saturated;

    merge_scoreboard sb = new();
    int entries_sent;

    cigar_run_merge_core #(
        .LEN_BITS(LEN_BITS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op_code         (op_code),
        .op_length       (op_length),
        .record_end      (record_end),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .merged_op       (merged_op),
        .merged_length   (merged_length),
        .last_of_record  (last_of_record),
        .record_empty    (record_empty),
        .length_saturated(length_saturated)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Note accepted entries and check accepted merged entries
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.take_entry(op_code, op_length, record_end);
        if (rst_n && out_valid && out_ready)
            sb.check_merged('{merged_op, merged_length, last_of_record,
                              record_empty, length_saturated});
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic [IN_LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        else if (r < 65)
            return IN_LEN_W'($urandom_range(1, 20));
        else if (r < 82)
            return IN_LEN_W'($urandom_range(1, 5000));
        else if (r < 92)
            return IN_LEN_W'($urandom());
        else
            return IN_MAX - IN_LEN_W'($urandom_range(0, 3));
    endfunction

    function automatic op_t pick_body_op();
        case ($urandom_range(0, 8))
            0: return OP_MATCH;
            1: return OP_DEL;
            2: return OP_SKIP;
            3: return OP_HARD;
            4: return OP_PAD;
            5: return OP_SEQ_EQ;
            6: return OP_SEQ_DIFF;
            7: return OP_SOFT;
            default: return OP_INS;
        endcase
    endfunction

    // Receiver: ready toggles with random hold times, with long clear stretches
    initial
    begin : out_stall
        int hold;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                out_ready <= 1'b0;
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
            end
            else
            begin
                out_ready <= 1'b1;
                hold = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                   : $urandom_range(1, 20);
            end
            repeat (hold) @(posedge clk);
        end
    end

    // Present one entry and hold it until accepted
    task automatic send_entry(op_t op, logic [IN_LEN_W-1:0] len, logic rec_end);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op_code    <= op;
        op_length  <= len;
        record_end <= rec_end;
        do
            @(posedge clk);
        while (!in_ready);
        entries_sent++;
    endtask

    // Stop sending until every owed merged entry has come out
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic run_directed();
        // records that give only the empty marker
        send_entry(OP_MATCH, '0, 1'b1);
        send_entry(OP_INS, '0, 1'b1);
        // all insertions become one soft clip
        send_entry(OP_INS, 28'd5, 1'b0);
        send_entry(OP_INS, 28'd3, 1'b1);
        // leading and trailing insertions clipped
        send_entry(OP_INS, 28'd2, 1'b0);
        send_entry(OP_MATCH, 28'd10, 1'b0);
        send_entry(OP_INS, 28'd3, 1'b0);
        send_entry(OP_INS, 28'd4, 1'b1);
        // zero-length deletion breaks the trailing run
        send_entry(OP_MATCH, 28'd5, 1'b0);
        send_entry(OP_INS, 28'd3, 1'b0);
        send_entry(OP_DEL, '0, 1'b0);
        send_entry(OP_INS, 28'd2, 1'b1);
        // clipped insertion merges with a soft clip; saturating match run
        send_entry(OP_INS, 28'd3, 1'b0);
        send_entry(OP_SOFT, 28'd4, 1'b0);
        send_entry(OP_MATCH, IN_MAX, 1'b0);
        send_entry(OP_MATCH, IN_MAX, 1'b1);
        // sum that just reaches the maximum
        send_entry(OP_SEQ_DIFF, IN_MAX - 1'b1, 1'b0);
        send_entry(OP_SEQ_DIFF, 28'd1, 1'b1);
        // extreme op codes, zero-length trailing insertion
        send_entry(OP_TOP, 28'd1, 1'b0);
        send_entry(OP_NONE, IN_MAX, 1'b0);
        send_entry(OP_INS, '0, 1'b1);
        // saturated inner insertion run
        send_entry(OP_MATCH, 28'd1, 1'b0);
        send_entry(OP_INS, IN_MAX, 1'b0);
        send_entry(OP_INS, IN_MAX, 1'b0);
        send_entry(OP_SKIP, 28'd2, 1'b1);
    endtask

    task automatic send_random_record();
        int  n_lead;
        int  n_body;
        int  n_tail;
        int  total;
        int  idx;
        int  i;
        op_t op;
        op_t prev;
        idx  = 0;
        prev = OP_MATCH;
        if ($urandom_range(0, 9) == 0)
        begin
            // noise: any op, any length
            total = $urandom_range(1, 6);
            for (i = 0; i < total; i++)
                send_entry(op_t'($urandom_range(0, 15)), pick_len(), i == total - 1);
        end
        else
        begin
            n_lead = $urandom_range(0, 2);
            n_body = $urandom_range(0, 5);
            n_tail = $urandom_range(0, 3);
            if (n_lead + n_body + n_tail == 0)
                n_body = 1;
            total = n_lead + n_body + n_tail;
            for (i = 0; i < n_lead; i++)
            begin
                idx++;
                send_entry(OP_INS, pick_len(), idx == total);
            end
            for (i = 0; i < n_body; i++)
            begin
                // repeat the previous op often so runs merge
                if (i > 0 && $urandom_range(0, 2) == 0)
                    op = prev;
                else
                    op = pick_body_op();
                prev = op;
                idx++;
                send_entry(op, pick_len(), idx == total);
            end
            for (i = 0; i < n_tail; i++)
            begin
                idx++;
                send_entry(OP_INS, pick_len(), idx == total);
            end
        end
    endtask

    initial
    begin : stimulus
        bit drained;
        int leftover;
        drained      = 1'b0;
        entries_sent = 0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        op_code    <= OP_NONE;
        op_length  <= '0;
        record_end <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain();

        entries_sent = 0;
        while (entries_sent < RANDOM_ENTRIES)
        begin
            send_random_record();
            if (!drained && entries_sent > RANDOM_ENTRIES / 2)
            begin
                drained = 1'b1;
                drain();
            end
        end

        // let everything owed come out, then idle before the final report
        drain();
        repeat (20) @(posedge clk);

        leftover = sb.pending();
        if (leftover != 0)
            $display("%0d merged entries never arrived", leftover);
        if (sb.errors == 0 && leftover == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/crm_pkg.sv
sv/crm_merge.sv
sv/crm_queue.sv
sv/cigar_run_merge_core.sv
tb/tb_cigar_run_merge_core.sv
